### rtl/key_debounce_rollover_tracker_defines.svh
// Assertion macros for the key tracker checker.
// Both expect signals named clock and reset in the scope of use.
`ifndef KEY_DEBOUNCE_ROLLOVER_TRACKER_DEFINES_SVH
`define KEY_DEBOUNCE_ROLLOVER_TRACKER_DEFINES_SVH

// Same-cycle implication.
`define KDRT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define KDRT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/kdrt_pkg.sv
`timescale 1ns / 1ps

package kdrt_pkg;

   localparam int CODE_W    = 8;
   localparam int KEY_W     = 7;
   localparam int MOD_W     = 8;
   localparam int CNT_W     = 4;
   localparam int MODSEL_W  = 3;
   localparam int SLOTS_OUT = 6;
   localparam int REPORTS   = 2;

   localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 4'd5;

   localparam int KEY_CODES_DEF = 136;
   localparam int BOARDS_DEF    = 2;
   localparam int ROLLOVER_DEF  = 6;

   typedef enum logic {
      KIND_SAMPLE   = 1'b0,
      KIND_SCAN_END = 1'b1
   } kdrt_kind_type;

   // One board's share of a key sample.
   typedef struct packed {
      logic                act;
      logic                add;
      logic                drop;
      logic                mod_set;
      logic                mod_clr;
      logic                set_change;
      logic [KEY_W-1:0]    key;
      logic [MODSEL_W-1:0] mod_bit;
   } kdrt_upd_type;

   typedef struct packed {
      logic                              changed;
      logic [MOD_W-1:0]                  mods;
      logic [SLOTS_OUT-1:0][KEY_W-1:0]   slot;
   } kdrt_rpt_type;

endpackage

### rtl/kdrt_req_if.sv
`timescale 1ns / 1ps

interface kdrt_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] key_code;
   logic       board;
   logic       pressed;

   modport source (output valid, kind, key_code, board, pressed, input ready);
   modport sink   (input valid, kind, key_code, board, pressed, output ready);
endinterface

### rtl/kdrt_rsp_if.sv
`timescale 1ns / 1ps

interface kdrt_rsp_if;
   logic       valid;
   logic       ready;
   logic       report_board;
   logic       changed;
   logic [7:0] modifier_bits;
   logic [6:0] slot_0;
   logic [6:0] slot_1;
   logic [6:0] slot_2;
   logic [6:0] slot_3;
   logic [6:0] slot_4;
   logic [6:0] slot_5;
   logic       last;

   modport source (output valid, report_board, changed, modifier_bits, slot_0, slot_1,
                   slot_2, slot_3, slot_4, slot_5, last, input ready);
   modport sink   (input valid, report_board, changed, modifier_bits, slot_0, slot_1,
                   slot_2, slot_3, slot_4, slot_5, last, output ready);
endinterface

### rtl/kdrt_cnt_ram.sv
`timescale 1ns / 1ps

module kdrt_cnt_ram import kdrt_pkg::*; #(
   parameter int DEPTH = BOARDS_DEF * KEY_CODES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [CNT_W-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [CNT_W-1:0]         wr_data,
   output logic                     clearing
);

   localparam int AW = $clog2(DEPTH);

   logic [CNT_W-1:0] mem [DEPTH];
   logic [CNT_W-1:0] rd_data_ff;
   logic             clr_busy_ff, clr_busy_in;
   logic [AW-1:0]    clr_addr_ff, clr_addr_in;
   logic             we;
   logic [AW-1:0]    wa;
   logic [CNT_W-1:0] wd;

   // Sweep writes the released value into every entry after reset.
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
      we = clr_busy_ff | wr_en;
      wa = clr_busy_ff ? clr_addr_ff : wr_addr;
      wd = clr_busy_ff ? DEBOUNCE_RESET : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_busy_ff;

endmodule

### rtl/kdrt_board_state.sv
`timescale 1ns / 1ps

module kdrt_board_state import kdrt_pkg::*; #(
   parameter int ROLLOVER = ROLLOVER_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  kdrt_upd_type upd,
   input  logic         clear_change,
   output kdrt_rpt_type rpt
);

   localparam int CW = $clog2(ROLLOVER + 1);

   logic [KEY_W-1:0] keys_ff [ROLLOVER];
   logic [KEY_W-1:0] keys_in [ROLLOVER];
   logic [KEY_W-1:0] keys_nx [ROLLOVER];
   logic [CW-1:0]    count_ff, count_in;
   logic [MOD_W-1:0] mods_ff, mods_in;
   logic             change_ff, change_in;
   logic [ROLLOVER-1:0]             from_hit;
   logic                            seen;
   logic                            full;
   logic [SLOTS_OUT-1:0][KEY_W-1:0] slots;

   always_comb begin
      // neighbour to the right, zero past the end
      for (int j = 0; j + 1 < ROLLOVER; j++) begin
         keys_nx[j] = keys_ff[j + 1];
      end
      keys_nx[ROLLOVER - 1] = '0;

      // from_hit marks the first matching entry and everything after it
      seen = 1'b0;
      for (int j = 0; j < ROLLOVER; j++) begin
         seen        = seen | ((CW'(j) < count_ff) && (keys_ff[j] == upd.key));
         from_hit[j] = seen;
      end
      full = (count_ff == CW'(ROLLOVER));

      keys_in   = keys_ff;
      count_in  = count_ff;
      mods_in   = mods_ff;
      change_in = change_ff;

      if (upd.act) begin
         if (upd.mod_set) begin
            mods_in = mods_ff | (MOD_W'(1) << upd.mod_bit);
         end
         if (upd.mod_clr) begin
            mods_in = mods_ff & ~(MOD_W'(1) << upd.mod_bit);
         end
         if (upd.add) begin
            if (full) begin
               // oldest falls out, new key goes in at the tail
               for (int j = 0; j < ROLLOVER; j++) begin
                  keys_in[j] = (j == ROLLOVER - 1) ? upd.key : keys_nx[j];
               end
            end else begin
               for (int j = 0; j < ROLLOVER; j++) begin
                  if (CW'(j) == count_ff) begin
                     keys_in[j] = upd.key;
                  end
               end
               count_in = count_ff + CW'(1);
            end
         end
         if (upd.drop && seen) begin
            for (int j = 0; j < ROLLOVER; j++) begin
               if (from_hit[j]) begin
                  keys_in[j] = keys_nx[j];
               end
            end
            count_in = count_ff - CW'(1);
         end
         if (upd.set_change) begin
            change_in = 1'b1;
         end
      end
      if (clear_change) begin
         change_in = 1'b0;
      end

      slots = '0;
      for (int s = 0; s < SLOTS_OUT && s < ROLLOVER; s++) begin
         slots[s] = keys_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < ROLLOVER; j++) begin
            keys_ff[j] <= '0;
         end
         count_ff  <= '0;
         mods_ff   <= '0;
         change_ff <= 1'b0;
      end else begin
         keys_ff   <= keys_in;
         count_ff  <= count_in;
         mods_ff   <= mods_in;
         change_ff <= change_in;
      end
   end

   assign rpt = '{changed: change_ff, mods: mods_ff, slot: slots};

endmodule

### rtl/kdrt_rsp_buf.sv
`timescale 1ns / 1ps

module kdrt_rsp_buf import kdrt_pkg::*; (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  kdrt_rpt_type [REPORTS-1:0]       rpt,
   output logic                             free,
   kdrt_rsp_if.source                       rsp_chan
);

   logic                        busy_ff, busy_in;
   logic                        idx_ff, idx_in;
   kdrt_rpt_type [REPORTS-1:0]  rpt_ff;
   kdrt_rpt_type                cur;

   always_comb begin
      free    = !busy_ff || (rsp_chan.ready && idx_ff);
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = 1'b0;
      end else if (busy_ff && rsp_chan.ready) begin
         if (idx_ff) begin
            busy_in = 1'b0;
         end else begin
            idx_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rpt_ff <= rpt;
      end
   end

   assign cur = rpt_ff[idx_ff];

   assign rsp_chan.valid         = busy_ff;
   assign rsp_chan.report_board  = idx_ff;
   assign rsp_chan.last          = idx_ff;
   assign rsp_chan.changed       = cur.changed;
   assign rsp_chan.modifier_bits = cur.mods;
   assign rsp_chan.slot_0        = cur.slot[0];
   assign rsp_chan.slot_1        = cur.slot[1];
   assign rsp_chan.slot_2        = cur.slot[2];
   assign rsp_chan.slot_3        = cur.slot[3];
   assign rsp_chan.slot_4        = cur.slot[4];
   assign rsp_chan.slot_5        = cur.slot[5];

endmodule

### rtl/key_debounce_rollover_tracker.sv
`timescale 1ns / 1ps
// Results: an end-of-scan is registered at intake and then loaded into the result buffer;
//   board 0's report shows first, board 1's once it is taken; key samples give no result.
// Throughput: one transaction per cycle, with a bypass for back-to-back counter updates,
//   unless an end-of-scan must wait for the result buffer to send both earlier reports.
// Reset: synchronous; then a sweep over BOARDS (at most 2) x KEY_CODES entries (272 by default)
//   loads every debounce counter with 5 while req_chan.ready is low.

module key_debounce_rollover_tracker import kdrt_pkg::*; #(
   parameter int KEY_CODES = KEY_CODES_DEF,
   parameter int BOARDS    = BOARDS_DEF,
   parameter int ROLLOVER  = ROLLOVER_DEF
) (
   input  logic             clock,
   input  logic             reset,
   kdrt_req_if.sink         req_chan,
   kdrt_rsp_if.source       rsp_chan,
   input  logic             csr_we,
   input  logic [CNT_W-1:0] csr_wdata
);

   // The board field is one bit, so no more than two boards can ever be addressed.
   localparam int USED_BOARDS = (BOARDS < REPORTS) ? BOARDS : REPORTS;
   localparam int CNT_DEPTH   = USED_BOARDS * KEY_CODES;
   localparam int CNT_AW      = $clog2(CNT_DEPTH);

   // ---------------------------------------------------------------- config
   logic [CNT_W-1:0] debounce_ff;
   logic [CNT_W-1:0] reload;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
      end else if (csr_we) begin
         debounce_ff <= csr_wdata;
      end
   end

   // a count of zero behaves as one
   assign reload = (debounce_ff == '0) ? CNT_W'(1) : debounce_ff;

   // ---------------------------------------------------------------- intake
   logic              accept;
   logic              clearing;
   logic              buf_free;
   logic              s1_adv;
   logic              hit_in;
   logic [CNT_AW-1:0] addr_in;

   logic              s1_valid_ff;
   kdrt_kind_type     s1_kind_ff;
   logic [CODE_W-1:0] s1_code_ff;
   logic              s1_board_ff;
   logic              s1_pressed_ff;
   logic              s1_hit_ff;
   logic [CNT_AW-1:0] s1_addr_ff;

   // Samples outside the code range, code zero, or for a missing board are dropped.
   assign hit_in = (kdrt_kind_type'(req_chan.kind) == KIND_SAMPLE)
                && (req_chan.key_code != '0)
                && ({1'b0, req_chan.key_code} < (CODE_W + 1)'(KEY_CODES))
                && (!req_chan.board || (USED_BOARDS > 1));

   assign addr_in = req_chan.board ? CNT_AW'(KEY_CODES) + CNT_AW'(req_chan.key_code)
                                   : CNT_AW'(req_chan.key_code);

   // Only an end-of-scan can stall, and only while the result buffer is still draining.
   assign s1_adv = s1_valid_ff && ((s1_kind_ff == KIND_SAMPLE) || buf_free);
   assign req_chan.ready = !clearing && (!s1_valid_ff || s1_adv);
   assign accept = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff    <= kdrt_kind_type'(req_chan.kind);
         s1_code_ff    <= req_chan.key_code;
         s1_board_ff   <= req_chan.board;
         s1_pressed_ff <= req_chan.pressed;
         s1_hit_ff     <= hit_in;
         s1_addr_ff    <= addr_in;
      end
   end

   // ---------------------------------------------------------------- counters
   logic [CNT_W-1:0]  ram_rdata;
   logic              cnt_we;
   logic [CNT_W-1:0]  cnt_wdata;
   logic [CNT_W-1:0]  cnt_cur;
   logic              fwd_valid_ff;
   logic [CNT_AW-1:0] fwd_addr_ff;
   logic [CNT_W-1:0]  fwd_data_ff;

   kdrt_cnt_ram #(
      .DEPTH (CNT_DEPTH)
   ) u_cnt_ram (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (addr_in),
      .rd_data  (ram_rdata),
      .wr_en    (cnt_we),
      .wr_addr  (s1_addr_ff),
      .wr_data  (cnt_wdata),
      .clearing (clearing)
   );

   // The read for the next transaction is issued on the same edge as this write-back,
   // so a back-to-back hit on the same key takes the value from the bypass register.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else begin
         fwd_valid_ff <= cnt_we;
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= cnt_wdata;
      end
   end

   assign cnt_cur = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : ram_rdata;
   assign cnt_we  = s1_valid_ff && s1_hit_ff;

   always_comb begin
      if (s1_pressed_ff) begin
         cnt_wdata = (cnt_cur == '0) ? '0 : cnt_cur - CNT_W'(1);
      end else begin
         cnt_wdata = reload;
      end
   end

   // ---------------------------------------------------------------- board state
   logic                       cnt_one;
   logic                       cnt_zero;
   logic                       is_mod;
   logic                       scan_end;
   kdrt_upd_type               upd_base;
   kdrt_rpt_type [REPORTS-1:0] rpts;

   assign cnt_one  = (cnt_cur == CNT_W'(1));
   assign cnt_zero = (cnt_cur == '0);
   assign is_mod   = s1_code_ff[CODE_W-1];
   assign scan_end = s1_valid_ff && (s1_kind_ff == KIND_SCAN_END) && buf_free;

   // press registers on the step from one to zero; release flags only a registered key
   always_comb begin
      upd_base.act        = cnt_we;
      upd_base.add        = s1_pressed_ff && cnt_one && !is_mod;
      upd_base.mod_set    = s1_pressed_ff && cnt_one && is_mod;
      upd_base.drop       = !s1_pressed_ff && !is_mod;
      upd_base.mod_clr    = !s1_pressed_ff && is_mod;
      upd_base.set_change = s1_pressed_ff ? cnt_one : cnt_zero;
      upd_base.key        = s1_code_ff[KEY_W-1:0];
      upd_base.mod_bit    = s1_code_ff[MODSEL_W-1:0];
   end

   for (genvar r = 0; r < REPORTS; r++) begin : g_board
      if (r < USED_BOARDS) begin : g_live
         kdrt_upd_type upd;

         always_comb begin
            upd     = upd_base;
            upd.act = upd_base.act && (s1_board_ff == 1'(r));
         end

         kdrt_board_state #(
            .ROLLOVER (ROLLOVER)
         ) u_board (
            .clock        (clock),
            .reset        (reset),
            .upd          (upd),
            .clear_change (scan_end),
            .rpt          (rpts[r])
         );
      end else begin : g_absent
         // a board that does not exist reports all zeros
         assign rpts[r] = '0;
      end
   end

   // ---------------------------------------------------------------- results
   kdrt_rsp_buf u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .load     (scan_end),
      .rpt      (rpts),
      .free     (buf_free),
      .rsp_chan (rsp_chan)
   );

endmodule

### rtl/kdrt_checker.sv
`timescale 1ns / 1ps
`include "key_debounce_rollover_tracker_defines.svh"

module kdrt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_report_board,
   input logic       rsp_changed,
   input logic [7:0] rsp_modifier_bits,
   input logic [6:0] rsp_slot_0,
   input logic [6:0] rsp_slot_1,
   input logic [6:0] rsp_slot_2,
   input logic [6:0] rsp_slot_3,
   input logic [6:0] rsp_slot_4,
   input logic [6:0] rsp_slot_5,
   input logic       rsp_last
);

   logic [52:0] rsp_word;
   logic        rsp_stall;
   logic        rsp_first;

   // whole report payload, for the hold check
   assign rsp_word  = {rsp_report_board, rsp_changed, rsp_modifier_bits, rsp_slot_0,
                       rsp_slot_1, rsp_slot_2, rsp_slot_3, rsp_slot_4, rsp_slot_5,
                       rsp_last};
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_first = rsp_valid && rsp_ready && !rsp_last;

   // counter sweep must keep intake closed straight after reset
   `KDRT_ASSERT_NOW(a_sweep_blocks, $past(reset), !req_ready, "intake open during sweep")

   // reports come in pairs: board 0 then board 1
   `KDRT_ASSERT_NOW(a_board_last, rsp_valid, rsp_report_board == rsp_last, "board/last mismatch")

   `KDRT_ASSERT_NXT(a_pair, rsp_first, rsp_valid && rsp_last, "second report missing")

   `KDRT_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_word), "stall not held")

endmodule

bind key_debounce_rollover_tracker kdrt_checker u_kdrt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_report_board  (rsp_chan.report_board),
   .rsp_changed       (rsp_chan.changed),
   .rsp_modifier_bits (rsp_chan.modifier_bits),
   .rsp_slot_0        (rsp_chan.slot_0),
   .rsp_slot_1        (rsp_chan.slot_1),
   .rsp_slot_2        (rsp_chan.slot_2),
   .rsp_slot_3        (rsp_chan.slot_3),
   .rsp_slot_4        (rsp_chan.slot_4),
   .rsp_slot_5        (rsp_chan.slot_5),
   .rsp_last          (rsp_chan.last)
);
